@@ rtl/cpm_pkg.sv @@
// Shared types and reset constants for the climate panel mode controller.
package cpm_pkg;

    typedef enum logic [1:0] {
        ST_OFF  = 2'd0,
        ST_AUTO = 2'd1,
        ST_DEF  = 2'd2,
        ST_IGN  = 2'd3
    } t_main_state;

    typedef enum logic [3:0] {
        EV_POWER    = 4'd0,
        EV_AUTO     = 4'd1,
        EV_DEFROST  = 4'd2,
        EV_AC       = 4'd3,
        EV_INTAKE   = 4'd4,
        EV_MODE     = 4'd5,
        EV_FAN_UP   = 4'd6,
        EV_FAN_DOWN = 4'd7,
        EV_TEMP_UP  = 4'd8,
        EV_TEMP_DN  = 4'd9,
        EV_REAR_DEF = 4'd10
    } t_event;

    typedef enum logic [1:0] {
        IGN_NONE     = 2'd0,
        IGN_LOST     = 2'd1,
        IGN_RESTORED = 2'd2
    } t_ign_event;

    localparam int unsigned EVENT_W   = 4;
    localparam int unsigned IGN_W     = 2;
    localparam int unsigned IN_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 24;

    // Panel status: the controller state and the reported result alike
    typedef struct packed {
        t_main_state main_state;
        t_main_state return_state;
        logic        intake_recirc;
        logic [2:0]  airflow_mode;
        logic [3:0]  blower_level;
        logic [6:0]  set_point_half;
        logic        rear_defrost_on;
        logic        intake_auto;
        logic        mode_auto;
        logic        blower_auto;
    } t_status;

    localparam t_status STATUS_RESET = '{
        main_state:      ST_OFF,
        return_state:    ST_AUTO,
        intake_recirc:   1'b0,
        airflow_mode:    3'd0,
        blower_level:    4'd0,
        set_point_half:  7'd50,
        rear_defrost_on: 1'b0,
        intake_auto:     1'b1,
        mode_auto:       1'b1,
        blower_auto:     1'b1
    };

endpackage

@@ rtl/cpm_step.sv @@
// Next-status logic: applies one ignition event and one button press to the status.
module cpm_step (
    input  cpm_pkg::t_status                i_cur,
    input  logic [cpm_pkg::EVENT_W-1:0]     i_event,
    input  logic [cpm_pkg::IGN_W-1:0]       i_ign,
    output cpm_pkg::t_status                o_next
);

    localparam logic [6:0] SP_LO   = 7'd0;
    localparam logic [6:0] SP_HI   = 7'd127;
    localparam logic [6:0] SP_MIN  = 7'd28;   // 14.0 degrees
    localparam logic [6:0] SP_MID1 = 7'd40;   // 20.0 degrees
    localparam logic [6:0] SP_MID2 = 7'd52;   // 26.0 degrees
    localparam logic [6:0] SP_MAX  = 7'd64;   // 32.0 degrees
    localparam logic [2:0] AF_DEFROST = 3'd4;
    localparam logic [3:0] BLOWER_MAX = 4'd8;

    function automatic logic [6:0] f_temp_up(input logic [6:0] s);
        logic [6:0] r;
        r = s;
        if (s == SP_LO)                          r = SP_MIN;
        else if (s >= SP_MIN  && s < SP_MID1)    r = s + 7'd2;
        else if (s >= SP_MID1 && s < SP_MID2)    r = s + 7'd1;
        else if (s >= SP_MID2 && s < SP_MAX)     r = s + 7'd2;
        else if (s == SP_MAX)                    r = SP_HI;
        return r;
    endfunction

    function automatic logic [6:0] f_temp_down(input logic [6:0] s);
        logic [6:0] r;
        r = s;
        if (s == SP_HI)                          r = SP_MAX;
        else if (s <= SP_MAX  && s > SP_MID2)    r = s - 7'd2;
        else if (s <= SP_MID2 && s > SP_MID1)    r = s - 7'd1;
        else if (s <= SP_MID1 && s > SP_MIN)     r = s - 7'd2;
        else if (s == SP_MIN)                    r = SP_LO;
        return r;
    endfunction

    cpm_pkg::t_status     s_n;
    cpm_pkg::t_main_state s_st;
    logic                 s_go;
    cpm_pkg::t_main_state s_go_tgt;
    logic                 s_leave;
    logic                 s_leave_intake;
    logic [2:0]           s_leave_mode;
    logic [3:0]           s_leave_blower;

    always_comb begin
        s_n            = i_cur;
        s_go           = 1'b0;
        s_go_tgt       = cpm_pkg::ST_AUTO;
        s_leave        = 1'b0;
        s_leave_intake = 1'b0;
        s_leave_mode   = AF_DEFROST;
        s_leave_blower = BLOWER_MAX;

        // ignition goes first, the button sees its outcome
        case (cpm_pkg::t_ign_event'(i_ign))
            cpm_pkg::IGN_LOST: begin
                s_n.main_state      = cpm_pkg::ST_IGN;
                s_n.rear_defrost_on = 1'b0;
            end
            cpm_pkg::IGN_RESTORED: begin
                if (s_n.main_state == cpm_pkg::ST_IGN) begin
                    s_n.main_state = cpm_pkg::ST_OFF;
                end
            end
            default: ;
        endcase

        s_st = s_n.main_state;

        if (s_st != cpm_pkg::ST_IGN) begin
            case (cpm_pkg::t_event'(i_event))
                cpm_pkg::EV_POWER: begin
                    s_go     = 1'b1;
                    s_go_tgt = (s_st == cpm_pkg::ST_OFF) ? s_n.return_state : cpm_pkg::ST_OFF;
                end
                cpm_pkg::EV_AUTO: begin
                    s_go            = 1'b1;
                    s_go_tgt        = cpm_pkg::ST_AUTO;
                    s_n.intake_auto = 1'b1;
                    s_n.mode_auto   = 1'b1;
                    s_n.blower_auto = 1'b1;
                end
                cpm_pkg::EV_DEFROST: begin
                    s_go     = 1'b1;
                    s_go_tgt = (s_st == cpm_pkg::ST_DEF) ? s_n.return_state : cpm_pkg::ST_DEF;
                end
                cpm_pkg::EV_AC: begin
                    if (s_st == cpm_pkg::ST_OFF) begin
                        if (s_n.return_state == cpm_pkg::ST_AUTO ||
                            s_n.return_state == cpm_pkg::ST_DEF) begin
                            s_go     = 1'b1;
                            s_go_tgt = s_n.return_state;
                        end
                    end else if (s_st == cpm_pkg::ST_AUTO) begin
                        s_go     = 1'b1;
                        s_go_tgt = cpm_pkg::ST_AUTO;
                    end else begin
                        s_leave = 1'b1;
                    end
                end
                cpm_pkg::EV_INTAKE: begin
                    if (s_st == cpm_pkg::ST_DEF) begin
                        s_leave        = 1'b1;
                        s_leave_intake = 1'b1;
                    end else begin
                        s_n.intake_recirc = ~s_n.intake_recirc;
                        s_n.intake_auto   = 1'b0;
                    end
                end
                cpm_pkg::EV_MODE: begin
                    if (s_st == cpm_pkg::ST_DEF) begin
                        s_leave      = 1'b1;
                        s_leave_mode = 3'd0;
                    end else begin
                        // unreachable codes above defrost are held
                        if (s_n.airflow_mode < AF_DEFROST) begin
                            s_n.airflow_mode = s_n.airflow_mode + 3'd1;
                        end else if (s_n.airflow_mode == AF_DEFROST) begin
                            s_n.airflow_mode = 3'd0;
                        end
                        s_n.mode_auto = 1'b0;
                    end
                end
                cpm_pkg::EV_FAN_UP: begin
                    if (s_st == cpm_pkg::ST_OFF) begin
                        s_go     = 1'b1;
                        s_go_tgt = s_n.return_state;
                    end else if (s_st == cpm_pkg::ST_AUTO) begin
                        if (s_n.blower_level < BLOWER_MAX) begin
                            s_n.blower_level = s_n.blower_level + 4'd1;
                        end
                        s_n.blower_auto = 1'b0;
                    end else begin
                        s_leave = 1'b1;
                    end
                end
                cpm_pkg::EV_FAN_DOWN: begin
                    if (s_st == cpm_pkg::ST_OFF) begin
                        s_go     = 1'b1;
                        s_go_tgt = s_n.return_state;
                    end else if (s_st == cpm_pkg::ST_AUTO) begin
                        if (s_n.blower_level > 4'd1) begin
                            s_n.blower_level = s_n.blower_level - 4'd1;
                        end
                        s_n.blower_auto = 1'b0;
                    end else begin
                        s_leave        = 1'b1;
                        s_leave_blower = BLOWER_MAX - 4'd1;
                    end
                end
                cpm_pkg::EV_TEMP_UP: begin
                    if (s_st != cpm_pkg::ST_OFF) begin
                        s_n.set_point_half = f_temp_up(s_n.set_point_half);
                    end
                end
                cpm_pkg::EV_TEMP_DN: begin
                    if (s_st != cpm_pkg::ST_OFF) begin
                        s_n.set_point_half = f_temp_down(s_n.set_point_half);
                    end
                end
                cpm_pkg::EV_REAR_DEF: begin
                    s_n.rear_defrost_on = ~s_n.rear_defrost_on;
                end
                default: ;
            endcase
        end

        // leaving defrost: back to auto with everything under manual control
        if (s_leave) begin
            s_go              = 1'b1;
            s_go_tgt          = cpm_pkg::ST_AUTO;
            s_n.intake_recirc = s_leave_intake;
            s_n.airflow_mode  = s_leave_mode;
            s_n.blower_level  = s_leave_blower;
            s_n.intake_auto   = 1'b0;
            s_n.mode_auto     = 1'b0;
            s_n.blower_auto   = 1'b0;
        end

        if (s_go) begin
            s_n.return_state = (s_st == cpm_pkg::ST_OFF || s_st == cpm_pkg::ST_IGN) ?
                               cpm_pkg::ST_AUTO : s_st;
            s_n.main_state   = s_go_tgt;
        end

        o_next = s_n;
    end

endmodule

@@ rtl/climate_panel_mode_fsm_top.sv @@
// Top level of the climate panel mode controller: stream ports, status and result registers.
//
// Climate panel mode controller. Each input transaction carries one button code and one
// ignition event; each yields exactly one output transaction with the full panel status.
// One transaction is taken per clock cycle while the output accepts; a result passes through
// the input register, then the status update and result register together. The status
// registers are updated in the same cycle the result is registered, so consecutive events
// chain without gaps. Back-pressure on the output stalls the input after one held item.
module climate_panel_mode_fsm_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [3:0] event_code, [5:4] ignition_event, [7:6] zero
    input  logic [cpm_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] main_state, [3:2] return_state, [4] intake_recirc, [7:5] airflow_mode,
    // [11:8] blower_level, [18:12] set_point_half, [19] rear_defrost_on,
    // [20] intake_auto, [21] mode_auto, [22] blower_auto, [23] zero
    output logic [cpm_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    logic                          r_in_valid;
    logic [cpm_pkg::EVENT_W-1:0]   r_in_event;
    logic [cpm_pkg::IGN_W-1:0]     r_in_ign;
    cpm_pkg::t_status              r_state;
    cpm_pkg::t_status              n_state;
    logic                          r_out_valid;
    cpm_pkg::t_status              r_out;
    logic                          s_consume;
    logic                          s_in_take;

    assign s_consume  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || s_consume;
    assign s_in_take  = i_s_tvalid && o_s_tready;

    cpm_step u_step (
        .i_cur   (r_state),
        .i_event (r_in_event),
        .i_ign   (r_in_ign),
        .o_next  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= cpm_pkg::STATUS_RESET;
        end else begin
            if (s_in_take) begin
                r_in_valid <= 1'b1;
            end else if (s_consume) begin
                r_in_valid <= 1'b0;
            end
            if (s_consume) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_event <= i_s_tdata[cpm_pkg::EVENT_W-1:0];
            r_in_ign   <= i_s_tdata[cpm_pkg::EVENT_W +: cpm_pkg::IGN_W];
        end
        if (s_consume) begin
            r_out <= n_state;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0,
                         r_out.blower_auto,
                         r_out.mode_auto,
                         r_out.intake_auto,
                         r_out.rear_defrost_on,
                         r_out.set_point_half,
                         r_out.blower_level,
                         r_out.airflow_mode,
                         r_out.intake_recirc,
                         r_out.return_state,
                         r_out.main_state};

endmodule

@@ verif/climate_panel_mode_fsm_top_tb.sv @@
// Self-checking testbench for the climate panel mode controller top level.
`timescale 1ns / 100ps

module climate_panel_mode_fsm_top_tb;
    import cpm_pkg::*;

    localparam int unsigned   RANDOM_EVENTS  = 1350;
    localparam int unsigned   WATCHDOG_LIMIT = 1000;
    localparam int unsigned   HOLD_CYCLES    = 120;
    localparam int unsigned   HOLD_AFTER     = 300;
    localparam int unsigned   DRAIN_CYCLES   = 8;
    localparam logic [1:0]    IGN_SPARE      = 2'd3;   // decodes as no ignition event
    localparam logic [3:0]    NO_BUTTON      = 4'd15;  // codes above rear defrost do nothing

    typedef struct packed {
        logic [1:0] ign;
        logic [3:0] ev;
    } t_panel_event;

    // Predicts the panel status for each event transaction and checks the results in order
    class panel_scoreboard;
        t_status     status;
        t_status     expected_q[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned taken;
        int unsigned acted;
        int unsigned lo_hits;
        int unsigned hi_hits;
        int unsigned ign_off_hits;

        function new();
            status       = STATUS_RESET;
            mismatches   = 0;
            checked      = 0;
            taken        = 0;
            acted        = 0;
            lo_hits      = 0;
            hi_hits      = 0;
            ign_off_hits = 0;
        endfunction

        function void enter_state(t_main_state nxt);
            t_main_state prev;
            prev = status.main_state;
            status.main_state   = nxt;
            status.return_state = (prev == ST_OFF || prev == ST_IGN) ? ST_AUTO : prev;
        endfunction

        // leaving defrost by a manual control drops all auto flags
        function void manual_from_defrost(logic recycle, logic [2:0] airflow,
                                          logic [3:0] blower);
            enter_state(ST_AUTO);
            status.intake_recirc  = recycle;
            status.airflow_mode   = airflow;
            status.blower_level   = blower;
            status.intake_auto    = 1'b0;
            status.mode_auto      = 1'b0;
            status.blower_auto    = 1'b0;
        endfunction

        // 1.0 degree steps at the ends, 0.5 in the middle band, LO/HI beyond
        function void step_set_point(bit up);
            logic [6:0] sp;
            sp = status.set_point_half;
            if (up) begin
                if (sp == 7'd0)                   sp = 7'd28;
                else if (sp >= 28 && sp < 40)     sp = sp + 7'd2;
                else if (sp >= 40 && sp < 52)     sp = sp + 7'd1;
                else if (sp >= 52 && sp < 64)     sp = sp + 7'd2;
                else if (sp == 7'd64)             sp = 7'd127;
            end else begin
                if (sp == 7'd127)                 sp = 7'd64;
                else if (sp <= 64 && sp > 52)     sp = sp - 7'd2;
                else if (sp <= 52 && sp > 40)     sp = sp - 7'd1;
                else if (sp <= 40 && sp > 28)     sp = sp - 7'd2;
                else if (sp == 7'd28)             sp = 7'd0;
            end
            status.set_point_half = sp;
        endfunction

        function void press(logic [3:0] ev);
            t_main_state st;
            st = status.main_state;
            if (st == ST_IGN) return;
            case (ev)
                EV_POWER: begin
                    if (st == ST_OFF) enter_state(status.return_state);
                    else              enter_state(ST_OFF);
                end
                EV_AUTO: begin
                    enter_state(ST_AUTO);
                    status.intake_auto = 1'b1;
                    status.mode_auto   = 1'b1;
                    status.blower_auto = 1'b1;
                end
                EV_DEFROST: begin
                    if (st == ST_DEF) enter_state(status.return_state);
                    else              enter_state(ST_DEF);
                end
                EV_AC: begin
                    if (st == ST_OFF) begin
                        if (status.return_state == ST_AUTO)     enter_state(ST_AUTO);
                        else if (status.return_state == ST_DEF) enter_state(ST_DEF);
                    end else if (st == ST_AUTO) begin
                        enter_state(ST_AUTO);
                    end else begin
                        manual_from_defrost(1'b0, 3'd4, 4'd8);
                    end
                end
                EV_INTAKE: begin
                    if (st == ST_DEF) begin
                        manual_from_defrost(1'b1, 3'd4, 4'd8);
                    end else begin
                        status.intake_recirc = ~status.intake_recirc;
                        status.intake_auto   = 1'b0;
                    end
                end
                EV_MODE: begin
                    if (st == ST_DEF) begin
                        manual_from_defrost(1'b0, 3'd0, 4'd8);
                    end else begin
                        if (status.airflow_mode < 3'd4)       status.airflow_mode++;
                        else if (status.airflow_mode == 3'd4) status.airflow_mode = 3'd0;
                        status.mode_auto = 1'b0;
                    end
                end
                EV_FAN_UP: begin
                    if (st == ST_OFF) begin
                        enter_state(status.return_state);
                    end else if (st == ST_AUTO) begin
                        if (status.blower_level < 4'd8) status.blower_level++;
                        status.blower_auto = 1'b0;
                    end else begin
                        manual_from_defrost(1'b0, 3'd4, 4'd8);
                    end
                end
                EV_FAN_DOWN: begin
                    if (st == ST_OFF) begin
                        enter_state(status.return_state);
                    end else if (st == ST_AUTO) begin
                        if (status.blower_level > 4'd1) status.blower_level--;
                        status.blower_auto = 1'b0;
                    end else begin
                        manual_from_defrost(1'b0, 3'd4, 4'd7);
                    end
                end
                EV_TEMP_UP: if (st != ST_OFF) step_set_point(1'b1);
                EV_TEMP_DN: if (st != ST_OFF) step_set_point(1'b0);
                EV_REAR_DEF: status.rear_defrost_on = ~status.rear_defrost_on;
                default: ;
            endcase
        endfunction

        function void note_event(logic [7:0] data);
            logic [3:0]  ev;
            logic [1:0]  ign;
            t_main_state st;
            ev  = data[3:0];
            ign = data[5:4];
            st  = status.main_state;
            taken++;
            if ((ign == IGN_LOST && st != ST_IGN) || (ign == IGN_RESTORED && st == ST_IGN) ||
                (st != ST_IGN && ev <= EV_REAR_DEF))
                acted++;
            // ignition is applied before the button
            if (ign == IGN_LOST) begin
                if (st != ST_IGN) ign_off_hits++;
                status.main_state      = ST_IGN;
                status.rear_defrost_on = 1'b0;
            end else if (ign == IGN_RESTORED && st == ST_IGN) begin
                status.main_state = ST_OFF;
            end
            press(ev);
            if (status.set_point_half == 7'd0)   lo_hits++;
            if (status.set_point_half == 7'd127) hi_hits++;
            expected_q.push_back(status);
        endfunction

        function void check_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_status(logic [OUT_DATA_W-1:0] d);
            t_status want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected status transaction, expected none, actual 0x%06h",
                         $time, d);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            check_field("main_state",      want.main_state,      d[1:0]);
            check_field("return_state",    want.return_state,    d[3:2]);
            check_field("intake_recirc",   want.intake_recirc,   d[4]);
            check_field("airflow_mode",    want.airflow_mode,    d[7:5]);
            check_field("blower_level",    want.blower_level,    d[11:8]);
            check_field("set_point_half",  want.set_point_half,  d[18:12]);
            check_field("rear_defrost_on", want.rear_defrost_on, d[19]);
            check_field("intake_auto",     want.intake_auto,     d[20]);
            check_field("mode_auto",       want.mode_auto,       d[21]);
            check_field("blower_auto",     want.blower_auto,     d[22]);
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    panel_scoreboard sb = new();
    int unsigned     burst_left = 0;

    always #2 i_clk = ~i_clk;

    climate_panel_mode_fsm_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Offers one event and returns once the transaction has been taken
    task automatic send_event(input logic [3:0] ev, input logic [1:0] ign);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ign, ev};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
    endtask

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (s_tvalid && o_s_tready) sb.note_event(s_tdata);
            if (o_m_tvalid && m_tready) sb.check_status(o_m_tdata);
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off to back the block up
    initial begin : status_sink
        int unsigned phase_left;
        int unsigned sink_mode;
        bit          held;
        phase_left = 0;
        sink_mode  = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (phase_left == 0) begin
                sink_mode  = $urandom_range(0, 3);
                phase_left = $urandom_range(32, 256);
            end
            phase_left--;
            case (sink_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("climate_panel_mode_fsm_top test failed");
        $finish;
    end

    initial begin : stimulus
        t_panel_event directed[];
        int unsigned kind;
        int unsigned run_len;
        logic [3:0]  ev;

        directed = '{
            '{IGN_NONE, EV_TEMP_UP},     // ignored while off
            '{IGN_NONE, EV_FAN_DOWN},    // wakes to the return state
            '{IGN_NONE, EV_POWER},
            '{IGN_NONE, EV_AC},
            '{IGN_NONE, EV_AC},
            '{IGN_NONE, EV_INTAKE},
            '{IGN_NONE, EV_MODE},
            '{IGN_NONE, EV_FAN_UP},
            '{IGN_NONE, EV_FAN_DOWN},
            '{IGN_NONE, EV_TEMP_UP},
            '{IGN_NONE, EV_TEMP_DN},
            '{IGN_NONE, EV_REAR_DEF},
            '{IGN_NONE, EV_AUTO},
            '{IGN_NONE, EV_DEFROST},
            '{IGN_NONE, EV_TEMP_DN},
            '{IGN_NONE, EV_AC},          // manual exit from defrost
            '{IGN_NONE, EV_DEFROST},
            '{IGN_NONE, EV_INTAKE},
            '{IGN_NONE, EV_DEFROST},
            '{IGN_NONE, EV_MODE},
            '{IGN_NONE, EV_DEFROST},
            '{IGN_NONE, EV_FAN_DOWN},
            '{IGN_LOST, EV_POWER},       // button dropped in ignition off
            '{IGN_RESTORED, EV_POWER},   // restore then power in one transaction
            '{IGN_SPARE, NO_BUTTON}
        };

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (directed[i]) send_event(directed[i].ev, directed[i].ign);

        while (sb.taken < directed.size() + RANDOM_EVENTS) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // runs of one button; long ones walk the set point to LO and HI
                ev = 4'($urandom_range(0, 10));
                run_len = (ev == EV_TEMP_UP || ev == EV_TEMP_DN) ? $urandom_range(1, 20)
                                                                 : $urandom_range(1, 4);
                repeat (run_len)
                    send_event(ev, ($urandom_range(0, 15) == 0) ? IGN_SPARE : IGN_NONE);
            end else if (kind < 88) begin
                send_event(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
            end else begin
                send_event(4'($urandom_range(0, 15)), IGN_LOST);
                repeat ($urandom_range(0, 3)) send_event(4'($urandom_range(0, 15)), IGN_NONE);
                send_event(4'($urandom_range(0, 15)), IGN_RESTORED);
                if ($urandom_range(0, 1)) send_event(EV_POWER, IGN_NONE);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d event transactions (%0d acted on), %0d status results checked.",
                 sb.taken, sb.acted, sb.checked);
        $display("Set point at LO %0d times, at HI %0d times; ignition off entered %0d times.",
                 sb.lo_hits, sb.hi_hits, sb.ign_off_hits);
        if (sb.mismatches == 0) begin
            $display("climate_panel_mode_fsm_top test passed");
        end else begin
            $display("climate_panel_mode_fsm_top test failed");
        end
        $finish;
    end

endmodule
